### rtl/rdbr_pkg.sv
// rdbr_pkg: shared types and constants for the reuse/dead-block replacement block.
// No dependencies.
package rdbr_pkg;
  localparam int NUM_SETS   = 2048;
  localparam int NUM_WAYS   = 16;
  localparam int SIG_BITS   = 6;
  localparam int ADDR_BITS  = 20;
  localparam int SET_W      = 11;
  localparam int WAY_W      = 4;
  localparam int PC_W       = 13;
  localparam int COUNT_BITS = 20;
  localparam int STRIDE_W   = ADDR_BITS + 1;
  localparam int ROW_W      = NUM_WAYS * 2;

  localparam logic [1:0] RV_MAX = 2'd3;
  localparam logic [1:0] DC_MAX = 2'd3;
  localparam logic [1:0] SC_MAX = 2'd3;
  localparam logic [2:0] STREAK_MAX = 3'd7;

  localparam logic       OP_VICTIM = 1'b0;
  localparam logic       OP_UPDATE = 1'b1;
  localparam logic       CFG_STREAM = 1'b0;
  localparam logic       CFG_DECAY  = 1'b1;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_READ, ST_VSEL, ST_VWR, ST_UCALC, ST_UWR,
    ST_DECAY_RD, ST_DECAY_WR, ST_OUT
  } rdbr_state_t;

  typedef struct packed {
    logic clear_step;
    logic load_item;
    logic read_rows;
    logic victim_calc;
    logic victim_write;
    logic upd_calc;
    logic upd_write;
    logic decay_read;
    logic decay_write;
    logic out_load;
  } rdbr_cmd_t;

  typedef struct packed {
    logic clear_done;
    logic is_update;
    logic decay_due;
    logic decay_last;
  } rdbr_sts_t;

  function automatic logic [SIG_BITS-1:0] pc_sig(input logic [PC_W-1:0] pc);
    logic [PC_W-1:0] t;
    t = (pc >> 2) ^ (pc >> 7);
    return t[SIG_BITS-1:0];
  endfunction
endpackage

### rtl/reuse_dead_block_replacement.sv
// Steps: a victim request passes READ, VSEL, VWR and OUT; an update passes READ,
// UCALC, UWR and OUT, with a decay sweep (a read and a write state per set) before OUT
// when one is due. One item in flight at a time; a new item is taken only in IDLE.
// Reset: synchronous active-low; afterwards a clearing pass over all sets of the
// set memories and signature counters runs with in_ready low. Config writes are always taken.
module reuse_dead_block_replacement import rdbr_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_opcode,
  input  logic [SET_W-1:0]     in_set_index,
  input  logic [WAY_W-1:0]     in_way,
  input  logic [ADDR_BITS-1:0] in_addr_low,
  input  logic [PC_W-1:0]      in_pc_low,
  input  logic                 in_hit,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [WAY_W-1:0]     out_victim_way,
  output logic                 out_streaming,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic                 cfg_index,
  input  logic [4:0]           cfg_data
);
  rdbr_cmd_t cmd;
  rdbr_sts_t sts;

  assign cfg_ready = 1'b1;

  rdbr_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready, .sts, .cmd
  );

  rdbr_dp u_dp (
    .clk, .rst_n, .cmd, .sts, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .in_opcode, .in_set_index, .in_way, .in_addr_low, .in_pc_low, .in_hit,
    .out_victim_way, .out_streaming
  );
endmodule

### rtl/rdbr_ctrl.sv
// rdbr_ctrl: sequencer for clear pass, victim, update and decay sweep.
// Depends on rdbr_pkg.
module rdbr_ctrl import rdbr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  output logic        out_valid,
  input  logic        out_ready,
  input  rdbr_sts_t   sts,
  output rdbr_cmd_t   cmd
);
  rdbr_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_CLEAR;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (sts.clear_done) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        cmd.read_rows = 1'b1;
        state_nxt = sts.is_update ? ST_UCALC : ST_VSEL;
      end
      ST_VSEL: begin
        cmd.victim_calc = 1'b1;
        state_nxt = ST_VWR;
      end
      ST_VWR: begin
        cmd.victim_write = 1'b1;
        cmd.out_load = 1'b1;
        state_nxt = ST_OUT;
      end
      ST_UCALC: begin
        cmd.upd_calc = 1'b1;
        state_nxt = ST_UWR;
      end
      ST_UWR: begin
        cmd.upd_write = 1'b1;
        cmd.out_load = 1'b1;
        state_nxt = sts.decay_due ? ST_DECAY_RD : ST_OUT;
      end
      ST_DECAY_RD: begin
        cmd.decay_read = 1'b1;
        state_nxt = ST_DECAY_WR;
      end
      ST_DECAY_WR: begin
        cmd.decay_write = 1'b1;
        state_nxt = sts.decay_last ? ST_OUT : ST_DECAY_RD;
      end
      ST_OUT: begin
        out_valid = 1'b1;
        if (out_ready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end
endmodule

### rtl/rdbr_dp.sv
// rdbr_dp: per-set memories, signature counters, stride tracker and victim logic.
// Depends on rdbr_pkg.
module rdbr_dp import rdbr_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  rdbr_cmd_t            cmd,
  output rdbr_sts_t            sts,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic                 cfg_index,
  input  logic [4:0]           cfg_data,
  input  logic                 in_opcode,
  input  logic [SET_W-1:0]     in_set_index,
  input  logic [WAY_W-1:0]     in_way,
  input  logic [ADDR_BITS-1:0] in_addr_low,
  input  logic [PC_W-1:0]      in_pc_low,
  input  logic                 in_hit,
  output logic [WAY_W-1:0]     out_victim_way,
  output logic                 out_streaming
);
  // row memories, one row per set
  logic [ROW_W-1:0]               rv_mem [NUM_SETS];
  logic [ROW_W-1:0]               dc_mem [NUM_SETS];
  logic [NUM_WAYS*SIG_BITS-1:0]   sg_mem [NUM_SETS];
  logic [ADDR_BITS-1:0]           la_mem [NUM_SETS];
  logic [STRIDE_W-1:0]            ls_mem [NUM_SETS];
  logic [2:0]                     sk_mem [NUM_SETS];
  logic [1:0]                     sc_r [2**SIG_BITS];

  logic [SET_W:0]             clr_r;
  logic [SET_W:0]             dec_r;
  logic [2:0]                 stream_len_r;
  logic [4:0]                 decay_log2_r;
  logic [COUNT_BITS-1:0]      ucnt_r;

  logic                       op_r, hit_r;
  logic [SET_W-1:0]           set_r;
  logic [WAY_W-1:0]           way_r;
  logic [ADDR_BITS-1:0]       addr_r;
  logic [SIG_BITS-1:0]        sig_r;

  logic [ROW_W-1:0]             rv_q, dc_q, rv_new_r, dc_new_r;
  logic [NUM_WAYS*SIG_BITS-1:0] sg_q;
  logic [ADDR_BITS-1:0]         la_q;
  logic [STRIDE_W-1:0]          ls_q, ls_new_r;
  logic [2:0]                   sk_q, sk_new_r;
  logic                         st_r;
  logic [WAY_W-1:0]             vic_r;
  logic [SIG_BITS-1:0]          old_sig_r;
  logic [1:0]                   sc_new_sig_r;
  logic [1:0]                   sc_cur_r;

  // config
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stream_len_r <= 3'd3;
      decay_log2_r <= 5'd13;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_STREAM: stream_len_r <= cfg_data[2:0];
        CFG_DECAY:  decay_log2_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) clr_r <= '0;
    else if (cmd.clear_step) clr_r <= clr_r + 1'b1;
  end
  assign sts.clear_done = (clr_r == (SET_W+1)'(NUM_SETS - 1));

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      op_r   <= in_opcode;
      hit_r  <= in_hit;
      set_r  <= in_set_index;
      way_r  <= in_way;
      addr_r <= in_addr_low;
      sig_r  <= pc_sig(in_pc_low);
    end
  end
  assign sts.is_update = (op_r == OP_UPDATE);

  // row reads
  always_ff @(posedge clk) begin
    if (cmd.read_rows) begin
      rv_q <= rv_mem[set_r];
      dc_q <= dc_mem[set_r];
      sg_q <= sg_mem[set_r];
      la_q <= la_mem[set_r];
      ls_q <= ls_mem[set_r];
      sk_q <= sk_mem[set_r];
      sc_cur_r <= sc_r[sig_r];
    end else if (cmd.decay_read) begin
      dc_q <= dc_mem[dec_r[SET_W-1:0]];
    end
  end

  // victim selection
  logic             v_dead_found;
  logic [WAY_W-1:0] v_dead_way, v_top_way;
  logic [1:0]       v_top;
  logic [ROW_W-1:0] rv_age;
  always_comb begin
    v_dead_found = 1'b0;
    v_dead_way = '0;
    v_top = '0;
    v_top_way = '0;
    for (int w = NUM_WAYS - 1; w >= 0; w--) begin
      if (dc_q[2*w +: 2] == 2'd0) begin
        v_dead_found = 1'b1;
        v_dead_way = WAY_W'(w);
      end
    end
    for (int w = 0; w < NUM_WAYS; w++) begin
      if (rv_q[2*w +: 2] > v_top) begin
        v_top = rv_q[2*w +: 2];
        v_top_way = WAY_W'(w);
      end
    end
    for (int w = 0; w < NUM_WAYS; w++)
      rv_age[2*w +: 2] = rv_q[2*w +: 2] + (RV_MAX - v_top);
  end

  always_ff @(posedge clk) begin
    if (cmd.victim_calc) vic_r <= v_dead_found ? v_dead_way : v_top_way;
  end

  // update calc
  logic [STRIDE_W-1:0] u_d;
  logic                u_st;
  logic [2:0]          u_sk;
  logic [STRIDE_W-1:0] u_ls;
  logic [1:0]          u_dc, u_old_dc;
  logic [1:0]          u_rv;
  logic [SIG_BITS-1:0] u_lsig;
  logic [ROW_W-1:0]    rv_upd, dc_upd;
  always_comb begin
    u_d = {1'b0, addr_r} - {1'b0, la_q};
    u_st = 1'b0;
    u_sk = 3'd1;
    u_ls = u_d;
    if (sk_q != 3'd0 && u_d == ls_q && u_d != '0) begin
      u_sk = (sk_q < STREAK_MAX) ? sk_q + 3'd1 : sk_q;
      u_ls = ls_q;
      u_st = (u_sk >= stream_len_r);
    end
    u_old_dc = dc_q[2*way_r +: 2];
    u_lsig = sg_q[SIG_BITS*way_r +: SIG_BITS];
    if (!hit_r) begin
      if (!u_st && (sc_cur_r == SC_MAX || u_old_dc != 2'd0)) begin
        u_rv = 2'd0; u_dc = DC_MAX;
      end else begin
        u_rv = RV_MAX; u_dc = 2'd0;
      end
    end else begin
      u_rv = 2'd0;
      u_dc = (u_old_dc < DC_MAX) ? u_old_dc + 2'd1 : u_old_dc;
    end
    rv_upd = rv_q;
    rv_upd[2*way_r +: 2] = u_rv;
    dc_upd = dc_q;
    dc_upd[2*way_r +: 2] = u_dc;
  end

  always_ff @(posedge clk) begin
    if (cmd.victim_calc) rv_new_r <= rv_age;
    else if (cmd.upd_calc) rv_new_r <= rv_upd;
  end

  always_ff @(posedge clk) begin
    if (cmd.upd_calc) begin
      st_r <= u_st;
      sk_new_r <= u_sk;
      ls_new_r <= u_ls;
      old_sig_r <= u_lsig;
      dc_new_r <= dc_upd;
      sc_new_sig_r <= sc_r[u_lsig];
    end
  end

  logic [COUNT_BITS-1:0] ucnt_inc;
  logic [4:0]            k;
  logic [COUNT_BITS-1:0] kmask;
  assign ucnt_inc = ucnt_r + 1'b1;
  assign k = (decay_log2_r > 5'd20) ? 5'd20 : decay_log2_r;
  assign kmask = COUNT_BITS'((32'd1 << k) - 32'd1);
  assign sts.decay_due = ((ucnt_inc & kmask) == '0);
  assign sts.decay_last = (dec_r == (SET_W+1)'(NUM_SETS - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) ucnt_r <= '0;
    else if (cmd.upd_write) ucnt_r <= ucnt_inc;
  end

  always_ff @(posedge clk) begin
    if (cmd.upd_write) dec_r <= '0;
    else if (cmd.decay_write) dec_r <= dec_r + 1'b1;
  end

  // signature counters, cleared by the clearing pass
  always_ff @(posedge clk) begin
    if (cmd.clear_step) begin
      sc_r[clr_r[SIG_BITS-1:0]] <= 2'd0;
    end else if (cmd.upd_write) begin
      if (!hit_r) begin
        if (sc_new_sig_r != 2'd0) sc_r[old_sig_r] <= sc_new_sig_r - 2'd1;
      end else if (sc_new_sig_r != SC_MAX) begin
        sc_r[old_sig_r] <= sc_new_sig_r + 2'd1;
      end
    end
  end

  logic [ROW_W-1:0] dc_dec;
  always_comb begin
    for (int w = 0; w < NUM_WAYS; w++)
      dc_dec[2*w +: 2] = (dc_q[2*w +: 2] != 2'd0) ? dc_q[2*w +: 2] - 2'd1 : 2'd0;
  end

  // memory writes
  always_ff @(posedge clk) begin
    if (cmd.clear_step) begin
      rv_mem[clr_r[SET_W-1:0]] <= '1;
      dc_mem[clr_r[SET_W-1:0]] <= '0;
      sg_mem[clr_r[SET_W-1:0]] <= '0;
      la_mem[clr_r[SET_W-1:0]] <= '0;
      ls_mem[clr_r[SET_W-1:0]] <= '0;
      sk_mem[clr_r[SET_W-1:0]] <= '0;
    end else if (cmd.victim_write) begin
      if (!v_dead_found) rv_mem[set_r] <= rv_new_r;
    end else if (cmd.upd_write) begin
      rv_mem[set_r] <= rv_new_r;
      dc_mem[set_r] <= dc_new_r;
      if (!hit_r) sg_mem[set_r][SIG_BITS*way_r +: SIG_BITS] <= sig_r;
      la_mem[set_r] <= addr_r;
      ls_mem[set_r] <= ls_new_r;
      sk_mem[set_r] <= sk_new_r;
    end else if (cmd.decay_write) begin
      dc_mem[dec_r[SET_W-1:0]] <= dc_dec;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_victim_way <= sts.is_update ? '0 : vic_r;
      out_streaming  <= sts.is_update ? st_r : 1'b0;
    end
  end
endmodule

### rtl/rdbr_checker.sv
// rdbr_checker: port-level assertions for reuse_dead_block_replacement, with bind.
// Depends on rdbr_pkg.
module rdbr_checker import rdbr_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic [WAY_W-1:0] out_victim_way,
  input logic             out_streaming
);
  a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid)) else $error("ready while result pending");
  a_no_out_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !out_valid) else $error("early result");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid && $stable(out_victim_way)
    && $stable(out_streaming)) else $error("result dropped");
  a_fields_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_victim_way == '0 || !out_streaming))
    else $error("both fields set");
endmodule

bind reuse_dead_block_replacement rdbr_checker u_chk (
  .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready,
  .out_victim_way, .out_streaming
);

### verif/testbench.sv
// Testbench for reuse_dead_block_replacement: drives victim requests and updates,
// predicts every result with an in-bench replacement model and checks each transfer.
// Depends on rdbr_pkg and the block's RTL.
`timescale 1ns / 100ps

module testbench;
  import rdbr_pkg::*;

  typedef struct {
    logic                 op;
    logic [SET_W-1:0]     set;
    logic [WAY_W-1:0]     way;
    logic [ADDR_BITS-1:0] addr;
    logic [PC_W-1:0]      pc;
    logic                 hit;
  } access_t;

  typedef struct {
    logic [WAY_W-1:0] victim;
    logic             streaming;
  } decision_t;

  localparam int WATCHDOG_LIMIT = 40000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_opcode = 1'b0;
  logic [SET_W-1:0] in_set_index = '0;
  logic [WAY_W-1:0] in_way = '0;
  logic [ADDR_BITS-1:0] in_addr_low = '0;
  logic [PC_W-1:0] in_pc_low = '0;
  logic in_hit = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [WAY_W-1:0] out_victim_way;
  logic out_streaming;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_index = 1'b0;
  logic [4:0] cfg_data = '0;

  reuse_dead_block_replacement dut (.*);

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // replacement model state
  logic [1:0] rrv [NUM_SETS][NUM_WAYS];
  logic [1:0] dead [NUM_SETS][NUM_WAYS];
  logic [SIG_BITS-1:0] line_sig [NUM_SETS][NUM_WAYS];
  logic [1:0] sig_ctr [1<<SIG_BITS];
  logic [ADDR_BITS-1:0] prev_addr [NUM_SETS];
  logic [STRIDE_W-1:0] prev_stride [NUM_SETS];
  logic [2:0] streak [NUM_SETS];
  logic [COUNT_BITS-1:0] upd_count;
  logic [2:0] stream_len;
  logic [4:0] decay_shift;

  access_t pending_q[$];
  decision_t decision_q[$];
  access_t cur;
  int errors = 0;

  function automatic void clear_model();
    for (int s = 0; s < NUM_SETS; s++) begin
      for (int w = 0; w < NUM_WAYS; w++) begin
        rrv[s][w] = RV_MAX;
        dead[s][w] = '0;
        line_sig[s][w] = '0;
      end
      prev_addr[s] = '0;
      prev_stride[s] = '0;
      streak[s] = '0;
    end
    for (int i = 0; i < (1 << SIG_BITS); i++) sig_ctr[i] = '0;
    upd_count = '0;
    stream_len = 3'd3;
    decay_shift = 5'd13;
  endfunction

  function automatic decision_t replace_decision(access_t a);
    decision_t r;
    logic [STRIDE_W-1:0] d;
    logic [SIG_BITS-1:0] sig, old;
    logic [1:0] top;
    int s, w, k;
    bit found;
    s = a.set;
    w = a.way;
    r.victim = '0;
    r.streaming = 1'b0;
    if (a.op == OP_VICTIM) begin
      found = 0;
      for (int i = 0; i < NUM_WAYS && !found; i++)
        if (dead[s][i] == 0) begin
          r.victim = WAY_W'(i);
          found = 1;
        end
      if (!found) begin
        top = '0;
        for (int i = 0; i < NUM_WAYS; i++)
          if (rrv[s][i] > top) begin
            top = rrv[s][i];
            r.victim = WAY_W'(i);
          end
        for (int i = 0; i < NUM_WAYS; i++) rrv[s][i] = rrv[s][i] + (RV_MAX - top);
      end
    end else begin
      d = {1'b0, a.addr} - {1'b0, prev_addr[s]};
      if (streak[s] == 0) begin
        prev_stride[s] = d;
        streak[s] = 3'd1;
      end else if (d == prev_stride[s] && d != 0) begin
        if (streak[s] < STREAK_MAX) streak[s]++;
        r.streaming = streak[s] >= stream_len;
      end else begin
        prev_stride[s] = d;
        streak[s] = 3'd1;
      end
      prev_addr[s] = a.addr;
      sig = pc_sig(a.pc);
      upd_count++;
      if (!a.hit) begin
        old = line_sig[s][w];
        if (!r.streaming && (sig_ctr[sig] == SC_MAX || dead[s][w] > 0)) begin
          rrv[s][w] = 2'd0;
          dead[s][w] = DC_MAX;
        end else begin
          rrv[s][w] = RV_MAX;
          dead[s][w] = 2'd0;
        end
        if (sig_ctr[old] > 0) sig_ctr[old]--;
        line_sig[s][w] = sig;
      end else begin
        rrv[s][w] = 2'd0;
        if (dead[s][w] < DC_MAX) dead[s][w]++;
        if (sig_ctr[line_sig[s][w]] < SC_MAX) sig_ctr[line_sig[s][w]]++;
      end
      k = decay_shift > COUNT_BITS ? COUNT_BITS : decay_shift;
      if ((upd_count & ((1 << k) - 1)) == 0)
        for (int s2 = 0; s2 < NUM_SETS; s2++)
          for (int w2 = 0; w2 < NUM_WAYS; w2++)
            if (dead[s2][w2] > 0) dead[s2][w2]--;
    end
    return r;
  endfunction

  // driver: bursts with random gaps
  int gap_left = 0;
  int burst_left = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) decision_q.push_back(replace_decision(cur));
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_q.size() > 0) begin
          cur = pending_q.pop_front();
          in_opcode <= cur.op;
          in_set_index <= cur.set;
          in_way <= cur.way;
          in_addr_low <= cur.addr;
          in_pc_low <= cur.pc;
          in_hit <= cur.hit;
          in_valid <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 30);
            gap_left = ($urandom % 3 == 0) ? 0 : $urandom_range(1, 12);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: checks each transfer against the model; receiver stall pattern is drawn at random
  int cyc = 0;
  int stall_mode = 0;
  always @(posedge clk) begin
    decision_t e;
    cyc++;
    if (cyc % 128 == 0) stall_mode = $urandom_range(0, 2);
    if (rst_n && out_valid && out_ready) begin
      if (decision_q.size() == 0) begin
        $error("unexpected transfer: victim_way %0d streaming %0d", out_victim_way,
               out_streaming);
        errors++;
      end else begin
        e = decision_q.pop_front();
        if (out_victim_way !== e.victim) begin
          $error("victim_way expected %0d actual %0d", e.victim, out_victim_way);
          errors++;
        end
        if (out_streaming !== e.streaming) begin
          $error("streaming expected %0d actual %0d", e.streaming, out_streaming);
          errors++;
        end
      end
    end
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= 1'($urandom_range(0, 1));
      default: out_ready <= ($urandom % 4 == 0);
    endcase
  end

  int idle_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready) || !rst_n)
      idle_cycles <= 0;
    else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end else
      idle_cycles <= idle_cycles + 1;
  end

  task automatic add(int op, int set, int way, int addr, int pc, int hit);
    access_t a;
    a.op = 1'(op);
    a.set = SET_W'(set);
    a.way = WAY_W'(way);
    a.addr = ADDR_BITS'(addr);
    a.pc = PC_W'(pc);
    a.hit = 1'(hit);
    pending_q.push_back(a);
  endtask

  task automatic drain();
    do @(posedge clk); while (pending_q.size() != 0 || in_valid || decision_q.size() != 0);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [4:0] v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_STREAM) stream_len = v[2:0];
    else decay_shift = v;
  endtask

  // stride streams on a small pool of sets, PCs from a small pool
  int pool_set [8];
  logic [ADDR_BITS-1:0] pool_addr [8];
  logic [ADDR_BITS-1:0] pool_stride [8];
  int pool_pc [8];

  task automatic add_random(int n);
    int i;
    for (int j = 0; j < n; j++) begin
      if ($urandom % 5 == 0) begin
        add($urandom_range(0, 1), $urandom_range(0, 2047), $urandom_range(0, 15),
            $urandom_range(0, 20'hFFFFF), $urandom_range(0, 13'h1FFF), $urandom_range(0, 1));
      end else begin
        i = $urandom_range(0, 7);
        if ($urandom % 10 < 3) begin
          add(OP_VICTIM, pool_set[i], $urandom_range(0, 15), 0, 0, 0);
        end else begin
          if ($urandom % 12 == 0)
            pool_stride[i] = ($urandom % 4 == 0) ? ADDR_BITS'(-$urandom_range(0, 256))
                                                 : ADDR_BITS'($urandom_range(0, 256));
          pool_addr[i] = pool_addr[i] + pool_stride[i];
          add(OP_UPDATE, pool_set[i], $urandom_range(0, 15), pool_addr[i],
              pool_pc[$urandom_range(0, 7)], $urandom_range(0, 1));
        end
      end
    end
  endtask

  task automatic new_pools();
    for (int i = 0; i < 8; i++) begin
      pool_set[i] = (i == 0) ? 2047 : $urandom_range(0, 2047);
      pool_addr[i] = ADDR_BITS'($urandom_range(0, 20'hFFFFF));
      pool_stride[i] = ADDR_BITS'($urandom_range(1, 64) << 2);
      pool_pc[i] = $urandom_range(0, 13'h1FFF);
    end
  endtask

  initial begin
    clear_model();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty set, stride stream, wrap, extremes, near insert after training
    add(OP_VICTIM, 0, 0, 0, 0, 0);
    add(OP_VICTIM, 2047, 15, 20'hFFFFF, 13'h1FFF, 1);
    for (int i = 0; i < 5; i++) add(OP_UPDATE, 5, i, 20'h100 + 20'h40 * i, 13'h0AC, 0);
    add(OP_UPDATE, 5, 5, 20'h200, 13'h0AC, 0);
    add(OP_UPDATE, 9, 0, 20'h00010, 13'h1FFF, 0);
    add(OP_UPDATE, 9, 1, 20'hFFFF0, 13'h1FFF, 0);
    add(OP_UPDATE, 9, 2, 20'hFFFD0, 13'h1FFF, 0);
    add(OP_UPDATE, 9, 3, 20'hFFFB0, 13'h1FFF, 0);
    for (int i = 0; i < 4; i++) add(OP_UPDATE, 2047, 15, 20'hFFFFF, 13'h1FFF, 1);
    add(OP_UPDATE, 2047, 14, 20'h12345, 13'h1FFF, 0);
    add(OP_UPDATE, 2047, 15, 20'h0, 13'h0, 0);
    add(OP_VICTIM, 2047, 0, 0, 0, 0);
    add(OP_VICTIM, 5, 0, 0, 0, 0);
    add(OP_UPDATE, 0, 0, 20'h0, 13'h0, 1);
    drain();

    new_pools();
    write_reg(CFG_STREAM, 5'd7);
    write_reg(CFG_DECAY, 5'd20);
    add_random(450);
    drain();

    write_reg(CFG_STREAM, 5'd2);
    write_reg(CFG_DECAY, 5'd1);
    add_random(24);
    drain();

    write_reg(CFG_STREAM, 5'd0);
    write_reg(CFG_DECAY, 5'd0);
    add_random(10);
    drain();

    new_pools();
    write_reg(CFG_STREAM, 5'd1);
    write_reg(CFG_DECAY, 5'd31);
    add_random(550);
    drain();

    write_reg(CFG_STREAM, 5'd13);
    write_reg(CFG_DECAY, 5'd4);
    add_random(550);
    drain();

    repeat (50) @(posedge clk);
    if (errors == 0) $display("testbench: clean");
    else $display("testbench: errors");
    $finish;
  end
endmodule
